// File: hdl/mbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants of the magnetorquer body torque unit
// Field widths, fixed-point sizes, pipeline depths and register codes.
// ----------------------------------------------------------------------------
package mbt_pkg;

	// item field widths
	localparam int MRP_W      = 16;
	localparam int FIELD_W    = 18;
	localparam int CMD_W      = 20;
	localparam int TORQUE_W   = 48;
	localparam int AXIS_W     = 16;
	localparam int LIM_LSB    = 48;
	localparam int BAR_REG_W  = 64;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int NBARS_HW   = 4;

	// stream payload widths (bytes filled up with zeros)
	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 144;
	localparam int FIELD_LSB   = 3 * MRP_W;
	localparam int CMD_LSB     = FIELD_LSB + 3 * FIELD_W;

	// attitude arithmetic
	localparam int S2_W        = 32;
	localparam int D_W         = 36;
	localparam int DIVIDEND_W  = 65;
	localparam int DIV_STEPS   = 37;
	localparam int DIP_W       = 36;
	localparam int M_W         = 38;
	localparam int B_W         = 21;

	// pipeline depths in register stages
	localparam int FRONT_LAT = 4;
	localparam int ROW_LAT   = DIV_STEPS + 7;
	localparam int PIPE_LAT  = FRONT_LAT + ROW_LAT + 2;

	typedef logic signed [MRP_W-1:0]   mrp_t;
	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [CMD_W-1:0]   cmd_t;
	typedef logic signed [DIP_W-1:0]   dip_t;
	typedef logic signed [M_W-1:0]     mom_t;
	typedef logic signed [B_W-1:0]     bfield_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BAR_COUNT = 3'd0,
		REG_BAR0      = 3'd1,
		REG_BAR1      = 3'd2,
		REG_BAR2      = 3'd3,
		REG_BAR3      = 3'd4
	} cfg_reg_t;

endpackage

// File: hdl/mbt_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_div_pipe: pipelined restoring divider
// One quotient bit per stage; the top dividend bits start as the remainder,
// which holds because the quotient always fits in DIV_STEPS bits.
// ----------------------------------------------------------------------------
module mbt_div_pipe import mbt_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [D_W-1:0]        divisor,
	output logic [DIV_STEPS-1:0]  quotient
);

	localparam int HI_W = DIVIDEND_W - DIV_STEPS;

	logic [D_W-1:0]       rem_q  [DIV_STEPS];
	logic [DIV_STEPS-1:0] rest_q [DIV_STEPS];
	logic [D_W-1:0]       dv_q   [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_q  [DIV_STEPS];

	logic [D_W-1:0]       rem_in  [DIV_STEPS];
	logic [DIV_STEPS-1:0] rest_in [DIV_STEPS];
	logic [D_W-1:0]       dv_in   [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo_in  [DIV_STEPS];
	logic [D_W:0]         trial   [DIV_STEPS];
	logic [D_W:0]         diff    [DIV_STEPS];
	logic                 ge      [DIV_STEPS];

	// feed each step from the previous stage
	always_comb begin
		rem_in[0]  = {{(D_W - HI_W){1'b0}}, dividend[DIVIDEND_W-1:DIV_STEPS]};
		rest_in[0] = dividend[DIV_STEPS-1:0];
		dv_in[0]   = divisor;
		quo_in[0]  = '0;
		for (int k = 1; k < DIV_STEPS; k++) begin
			rem_in[k]  = rem_q[k-1];
			rest_in[k] = rest_q[k-1];
			dv_in[k]   = dv_q[k-1];
			quo_in[k]  = quo_q[k-1];
		end
	end

	// trial subtract, one bit per step
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			trial[k] = {rem_in[k], rest_in[k][DIV_STEPS-1]};
			diff[k]  = trial[k] - {1'b0, dv_in[k]};
			ge[k]    = (trial[k] >= {1'b0, dv_in[k]});
		end
	end

	// advance the stages
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				rem_q[k]  <= ge[k] ? diff[k][D_W-1:0] : trial[k][D_W-1:0];
				rest_q[k] <= {rest_in[k][DIV_STEPS-2:0], 1'b0};
				dv_q[k]   <= dv_in[k];
				quo_q[k]  <= {quo_in[k][DIV_STEPS-2:0], ge[k]};
			end
		end
	end

	assign quotient = quo_q[DIV_STEPS-1];

endmodule

// File: hdl/mbt_bar_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_bar_lane: one torque bar
// Clamps the bar's command to its limit and weights the bar axis by it.
// ----------------------------------------------------------------------------
module mbt_bar_lane import mbt_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 use_bar,
	input  logic [BAR_REG_W-1:0] bar_reg,
	input  cmd_t                 cmd,
	output dip_t                 dip [3]
);

	logic signed [CMD_W:0] lim_w;
	logic signed [CMD_W:0] nlim_w;
	logic signed [CMD_W:0] cmd_w;
	cmd_t                  clip;
	cmd_t                  clip_s1;
	logic signed [AXIS_W-1:0] ax [3];
	dip_t                  dip_s2 [3];

	// clamp to plus or minus the limit, drop unused bars
	always_comb begin
		lim_w  = $signed({{(CMD_W + 1 + LIM_LSB - BAR_REG_W){1'b0}},
			bar_reg[BAR_REG_W-1:LIM_LSB]});
		nlim_w = -lim_w;
		cmd_w  = {cmd[CMD_W-1], cmd};
		if (!use_bar)
			clip = '0;
		else if (cmd_w > lim_w)
			clip = lim_w[CMD_W-1:0];
		else if (cmd_w < nlim_w)
			clip = nlim_w[CMD_W-1:0];
		else
			clip = cmd;
		for (int i = 0; i < 3; i++)
			ax[i] = $signed(bar_reg[AXIS_W*i +: AXIS_W]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_s1 <= clip;
			for (int i = 0; i < 3; i++)
				dip_s2[i] <= ax[i] * clip_s1;
		end
	end

	assign dip = dip_s2;

endmodule

// File: hdl/mbt_row_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbt_row_lane: one row of the attitude matrix
// Builds the three entries of row ROW from the MRP vector, divides each by
// the shared denominator and takes the row's dot product with the field.
// ----------------------------------------------------------------------------
module mbt_row_lane import mbt_pkg::*; #(
	parameter int ROW = 0
) (
	input  logic            clk,
	input  logic            en,
	input  mrp_t            s   [3],
	input  logic [S2_W-1:0] s2,
	input  logic [D_W-1:0]  d,
	input  field_t          f   [3],
	output bfield_t         b
);

	localparam int F_DLY = 4 + DIV_STEPS + 1;

	logic signed [16:0] se [3];
	logic signed [16:0] sk [3];
	logic signed [31:0] prod_s1 [3];
	logic signed [16:0] sk_s1 [3];
	logic signed [33:0] w_s1;
	logic [S2_W-1:0]    s2_s1;
	logic [D_W-1:0]     d_s1, d_s2, d_s3, d_s4;
	logic signed [33:0] sq_s2 [3];
	logic signed [50:0] tw_s2 [3];
	logic signed [53:0] n_s3 [3];
	logic [53:0]        mag [3];
	logic [DIVIDEND_W-1:0] dvd_s4 [3];
	logic [2:0]         neg_s4;
	logic [2:0]         neg_dly [DIV_STEPS];
	logic [DIV_STEPS-1:0] quo [3];
	logic signed [38:0] cq [3];
	logic signed [38:0] c_s5 [3];
	logic signed [56:0] pr_s6 [3];
	logic signed [58:0] acc;
	bfield_t            b_s7;
	field_t             f_dly [F_DLY][3];

	// cross-product matrix row
	always_comb begin
		for (int k = 0; k < 3; k++)
			se[k] = {s[k][MRP_W-1], s[k]};
		case (ROW)
			0:       sk = '{17'sd0, -se[2], se[1]};
			1:       sk = '{se[2], 17'sd0, -se[0]};
			default: sk = '{-se[1], se[0], 17'sd0};
		endcase
	end

	// absolute numerator for the divider
	always_comb begin
		for (int j = 0; j < 3; j++)
			mag[j] = n_s3[j][53] ? 54'(-n_s3[j]) : n_s3[j];
	end

	// sign back and add the identity on the diagonal
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			cq[j] = neg_dly[DIV_STEPS-1][j] ? -$signed({2'b00, quo[j]})
				: $signed({2'b00, quo[j]});
			if (j == ROW)
				cq[j] = cq[j] + 39'sd268435456;
		end
		acc = 59'(pr_s6[0]) + 59'(pr_s6[1]) + 59'(pr_s6[2]) + 59'sd134217728;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// products and scaled terms
			s2_s1 <= s2;
			d_s1  <= d;
			w_s1  <= 34'sd268435456 - $signed({2'b00, s2});
			for (int j = 0; j < 3; j++) begin
				prod_s1[j] <= s[ROW] * s[j];
				sk_s1[j]   <= sk[j];
			end
			// symmetric part and skew part
			d_s2 <= d_s1;
			for (int j = 0; j < 3; j++) begin
				sq_s2[j] <= {{2{prod_s1[j][31]}}, prod_s1[j]}
					- ((j == ROW) ? {2'b00, s2_s1} : 34'd0);
				tw_s2[j] <= w_s1 * sk_s1[j];
			end
			// numerator
			d_s3 <= d_s2;
			for (int j = 0; j < 3; j++)
				n_s3[j] <= {{3{sq_s2[j][33]}}, sq_s2[j], 17'b0}
					- {tw_s2[j][50], tw_s2[j], 2'b0};
			// dividend with half the divisor for rounding
			d_s4 <= d_s3;
			for (int j = 0; j < 3; j++) begin
				neg_s4[j] <= n_s3[j][53];
				dvd_s4[j] <= {mag[j][50:0], 14'b0} + {30'b0, d_s3[D_W-1:1]};
			end
			// hold signs and field while the divider works
			neg_dly[0] <= neg_s4;
			for (int k = 1; k < DIV_STEPS; k++)
				neg_dly[k] <= neg_dly[k-1];
			f_dly[0] <= f;
			for (int k = 1; k < F_DLY; k++)
				f_dly[k] <= f_dly[k-1];
			// matrix entries, products, rounded sum
			c_s5 <= cq;
			for (int j = 0; j < 3; j++)
				pr_s6[j] <= c_s5[j] * f_dly[F_DLY-1][j];
			b_s7 <= acc[48:28];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_div
		mbt_div_pipe u_div (
			.clk      (clk),
			.en       (en),
			.dividend (dvd_s4[j]),
			.divisor  (d_s4),
			.quotient (quo[j])
		);
	end

	assign b = b_s7;

endmodule

// File: hdl/magnetorquer_body_torque_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetorquer_body_torque_unit: body torque of a set of torque bars
// Rotates the inertial field into the body frame and returns m x B.
// ----------------------------------------------------------------------------
// Unless halted, the unit takes one item per clock and returns its torque
// through 50 pipeline stages and the output register, a depth set by the
// nine 37-stage dividers, three per matrix row lane, forming the rotation
// matrix entries. An output register with a skid stage lets the pipeline
// take a new item while a result waits; it halts only while the skid stage
// is full. Configuration must be written while idle; this is not enforced.
// ----------------------------------------------------------------------------
module magnetorquer_body_torque_unit import mbt_pkg::*; #(
	parameter int MAX_BARS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BAR_REG_W-1:0]   cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// mrp_x, mrp_y, mrp_z, field_inertial_x/y/z, dipole_cmd_0..3, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// torque_body_x, torque_body_y, torque_body_z
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [CNT_W-1:0]     count_q;
	logic [BAR_REG_W-1:0] bar_q [MAX_BARS];

	logic en, accept, arrive, load_out, load_skid, unload_skid;
	logic [PIPE_LAT-1:0] vld_q;

	mrp_t   s_s1 [3], s_s2 [3], s_s3 [3], s_s4 [3];
	field_t f_s1 [3], f_s2 [3], f_s3 [3], f_s4 [3];
	cmd_t   cmd_s1 [MAX_BARS];
	logic signed [31:0] sqp [3];
	logic [30:0]        sq_s2 [3];
	logic [S2_W-1:0]    s2_s3, s2_s4;
	logic [S2_W-1:0]    p;
	logic [63:0]        pp;
	logic [D_W-1:0]     d_s4;

	dip_t    dip_w [MAX_BARS][3];
	mom_t    msum [3];
	mom_t    m_s4 [3];
	mom_t    m_dly [ROW_LAT][3];
	bfield_t b_w [3];
	logic signed [58:0] cp_s49 [6];
	logic signed [59:0] tq [3];
	logic [TORQUE_W-1:0] tq_s50 [3];
	logic [OUT_TDATA_W-1:0] pack, out_q, skid_data_q;
	logic out_v_q, skid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int k = 0; k < MAX_BARS; k++)
				bar_q[k] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BAR_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: begin
					for (int k = 0; k < MAX_BARS; k++)
						if (cfg_index == CFG_IDX_W'(k + 1))
							bar_q[k] <= cfg_data;
				end
			endcase
		end
	end

	// handshake: the pipeline halts only while the skid stage holds an item
	assign en            = !skid_q;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign arrive        = en && vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[PIPE_LAT-2:0], accept};
	end

	// front: squares, norm and denominator
	always_comb begin
		for (int i = 0; i < 3; i++)
			sqp[i] = s_s1[i] * s_s1[i];
		p  = s2_s3 + 32'h1000_0000;
		pp = 64'(p) * 64'(p);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= s_axis_tdata[MRP_W*i +: MRP_W];
				f_s1[i] <= s_axis_tdata[FIELD_LSB + FIELD_W*i +: FIELD_W];
			end
			for (int k = 0; k < MAX_BARS; k++)
				cmd_s1[k] <= s_axis_tdata[CMD_LSB + CMD_W*k +: CMD_W];
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= sqp[i][30:0];
			s_s2  <= s_s1;
			f_s2  <= f_s1;
			s2_s3 <= 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);
			s_s3  <= s_s2;
			f_s3  <= f_s2;
			d_s4  <= pp[63:28];
			s2_s4 <= s2_s3;
			s_s4  <= s_s3;
			f_s4  <= f_s3;
		end
	end

	// bar lanes
	for (genvar k = 0; k < MAX_BARS; k++) begin : g_bar
		mbt_bar_lane u_bar (
			.clk     (clk),
			.en      (en),
			.use_bar (count_q > CNT_W'(k)),
			.bar_reg (bar_q[k]),
			.cmd     (cmd_s1[k]),
			.dip     (dip_w[k])
		);
	end

	// sum the bar dipoles and hold them beside the row lanes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msum[i] = '0;
			for (int k = 0; k < MAX_BARS; k++)
				msum[i] = msum[i] + M_W'(dip_w[k][i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s4     <= msum;
			m_dly[0] <= m_s4;
			for (int k = 1; k < ROW_LAT; k++)
				m_dly[k] <= m_dly[k-1];
		end
	end

	// rotation row lanes
	for (genvar r = 0; r < 3; r++) begin : g_row
		mbt_row_lane #(.ROW(r)) u_row (
			.clk (clk),
			.en  (en),
			.s   (s_s4),
			.s2  (s2_s4),
			.d   (d_s4),
			.f   (f_s4),
			.b   (b_w[r])
		);
	end

	// merge: cross product, round and fit to the torque field
	always_comb begin
		tq[0] = 60'(cp_s49[0]) - 60'(cp_s49[1]) + 60'sd8192;
		tq[1] = 60'(cp_s49[2]) - 60'(cp_s49[3]) + 60'sd8192;
		tq[2] = 60'(cp_s49[4]) - 60'(cp_s49[5]) + 60'sd8192;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cp_s49[0] <= m_dly[ROW_LAT-1][1] * b_w[2];
			cp_s49[1] <= m_dly[ROW_LAT-1][2] * b_w[1];
			cp_s49[2] <= m_dly[ROW_LAT-1][2] * b_w[0];
			cp_s49[3] <= m_dly[ROW_LAT-1][0] * b_w[2];
			cp_s49[4] <= m_dly[ROW_LAT-1][0] * b_w[1];
			cp_s49[5] <= m_dly[ROW_LAT-1][1] * b_w[0];
			// the 46-bit rounded torque always lies inside the 48-bit range
			for (int i = 0; i < 3; i++)
				tq_s50[i] <= {{2{tq[i][59]}}, tq[i][59:14]};
		end
	end

	// output register and skid stage
	assign pack        = {tq_s50[2], tq_s50[1], tq_s50[0]};
	assign unload_skid = skid_q && m_axis_tready;
	assign load_skid   = arrive && out_v_q && !m_axis_tready;
	assign load_out    = arrive && !(out_v_q && !m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_q  <= 1'b0;
		end else if (unload_skid) begin
			skid_q <= 1'b0;
		end else if (load_skid) begin
			skid_q <= 1'b1;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (unload_skid)
			out_q <= skid_data_q;
		else if (load_out)
			out_q <= pack;
		if (load_skid)
			skid_data_q <= pack;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> m_axis_tvalid)
		else $error("skid stage full without a valid output");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(arrive && m_axis_tvalid && !m_axis_tready) |=> skid_q)
		else $error("item reached a stalled output without entering the skid stage");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_q && m_axis_tready) |=> (m_axis_tvalid && !skid_q))
		else $error("skid item not moved to the output");
`endif

endmodule
